[design/spqu_pkg.sv]
package spqu_pkg;

    // Command codes of the input channel
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes of the result channel
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // Fixed width of the entry-count result field
    localparam int OUT_COUNT_W = 5;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

[design/spqu_cell.sv]
module spqu_cell #(
    parameter int KEY_WIDTH  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                         aclk,
    input  spqu_pkg::cell_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [KEY_WIDTH-1:0]  new_key,
    input  logic [DATA_WIDTH-1:0]        new_data,
    input  logic                         left_le,
    input  logic signed [KEY_WIDTH-1:0]  left_key,
    input  logic [DATA_WIDTH-1:0]        left_data,
    input  logic signed [KEY_WIDTH-1:0]  right_key,
    input  logic [DATA_WIDTH-1:0]        right_data,
    output logic                         le,
    output logic signed [KEY_WIDTH-1:0]  key,
    output logic [DATA_WIDTH-1:0]        data,
    output logic [DATA_WIDTH-1:0]        data_next
);

    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0]       data_reg;
    logic                        occupied;

    // Cell holds an entry when its slot lies below the fill count
    assign occupied = (count > CNT_W'(INDEX));

    // Entry stays put on insert when it leaves no later than the new one
    assign le = occupied && (key_reg <= new_key);

    // Pick the next entry: keep, take the new one, or shift from a neighbor
    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        if (ctrl.insert && !le) begin
            if (left_le) begin
                key_next  = new_key;
                data_next = new_data;
            end else begin
                key_next  = left_key;
                data_next = left_data;
            end
        end else if (ctrl.remove) begin
            key_next  = right_key;
            data_next = right_data;
        end
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key  = key_reg;
    assign data = data_reg;

endmodule

[design/stable_priority_queue_unit.sv]
// Channel  | Ports                                     | Direction
// ---------+-------------------------------------------+----------
// request  | s_valid s_ready s_cmd s_priority_req s_data | in
// result   | m_valid m_ready m_removed_data m_front_data | out
//          | m_front_valid m_entry_count m_status        |
//
// One request per cycle while m_ready keeps s_ready high: every cell compares
// and shifts in parallel, so an insert or remove settles at the clock edge that
// accepts it, and the result shows in the next cycle from the output register.
// Reset (aresetn low, synchronous) empties the queue and drops any result.
// A result held on the output blocks new requests only while m_ready is low.
module stable_priority_queue_unit #(
    parameter int CAPACITY   = 16,
    parameter int KEY_WIDTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [15:0] s_priority_req,
    input  logic signed [31:0] s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_removed_data,
    output logic signed [31:0] m_front_data,
    output logic               m_front_valid,
    output logic [4:0]         m_entry_count,
    output logic [1:0]         m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        m_valid_reg;
    logic [31:0]                 removed_reg, front_reg;
    logic                        front_valid_reg;
    logic [4:0]                  entry_count_reg;
    logic [1:0]                  status_reg, status_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    spqu_pkg::cell_ctrl_t        ctrl;
    logic signed [31:0]          key32;
    logic signed [63:0]          data64;
    logic signed [KEY_WIDTH-1:0] new_key;
    logic [DATA_WIDTH-1:0]       new_data;

    logic                        le_chain   [CAPACITY+1];
    logic signed [KEY_WIDTH-1:0] key_chain  [CAPACITY+2];
    logic [DATA_WIDTH-1:0]       data_chain [CAPACITY+2];
    logic [DATA_WIDTH-1:0]       head_next;
    logic [63:0]                 head_now64, head_next64, count64;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Widen the request fields, then keep the stored widths
    assign key32    = 32'(s_priority_req);
    assign data64   = 64'(s_data);
    assign new_key  = key32[KEY_WIDTH-1:0];
    assign new_data = data64[DATA_WIDTH-1:0];

    // Decode the command and the next fill count
    always_comb begin
        ctrl        = '0;
        status_next = spqu_pkg::STATUS_OK;
        count_next  = count_reg;
        if (accept) begin
            if (s_cmd == spqu_pkg::CMD_INSERT) begin
                if (full) begin
                    status_next = spqu_pkg::STATUS_OVERFLOW;
                end else begin
                    ctrl.insert = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status_next = spqu_pkg::STATUS_UNDERFLOW;
                end else begin
                    ctrl.remove = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    // Chain ends: the head always sees the new entry, the tail shifts in zeros
    assign le_chain[0]            = 1'b1;
    assign key_chain[0]           = '0;
    assign data_chain[0]          = '0;
    assign key_chain[CAPACITY+1]  = '0;
    assign data_chain[CAPACITY+1] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] cell_data_next;

        spqu_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .new_key    (new_key),
            .new_data   (new_data),
            .left_le    (le_chain[i]),
            .left_key   (key_chain[i]),
            .left_data  (data_chain[i]),
            .right_key  (key_chain[i+2]),
            .right_data (data_chain[i+2]),
            .le         (le_chain[i+1]),
            .key        (key_chain[i+1]),
            .data       (data_chain[i+1]),
            .data_next  (cell_data_next)
        );
    end

    assign head_next   = g_cell[0].cell_data_next;
    assign head_now64  = 64'(data_chain[1]);
    assign head_next64 = 64'(head_next);
    assign count64     = 64'(count_next);

    // Advance the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            removed_reg     <= ctrl.remove ? head_now64[31:0] : '0;
            front_reg       <= (count_next != '0) ? head_next64[31:0] : '0;
            front_valid_reg <= (count_next != '0);
            entry_count_reg <= count64[spqu_pkg::OUT_COUNT_W-1:0];
            status_reg      <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_removed_data = removed_reg;
    assign m_front_data   = front_reg;
    assign m_front_valid  = front_valid_reg;
    assign m_entry_count  = entry_count_reg;
    assign m_status       = status_reg;

endmodule
